// ===== rtl/tcw_pkg.sv =====
// Text console writer: shared types and constants.
// Used by the top level, the cell walker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;

	localparam logic [1:0] OP_PUT_CHAR  = 2'd0;
	localparam logic [1:0] OP_CLEAR     = 2'd1;
	localparam logic [1:0] OP_MOVE_TO   = 2'd2;
	localparam logic [1:0] OP_READ_CELL = 2'd3;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_RETURN  = 8'h0D;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] ATTR_DEFAULT = 8'h0F;

	localparam logic [COL_W-1:0] COLUMNS_RESET = 7'd80;
	localparam logic [ROW_W-1:0] ROWS_RESET    = 5'd25;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	// Command for the cell walker: fill every cell, or scroll up one row
	typedef struct packed {
		logic              scroll;
		logic [CELL_W-1:0] fill;
	} walk_cmd_t;

endpackage

// ===== rtl/text_console_writer_core.sv =====
// Text console writer top level: command stream in, one result beat per command out.
// Depends on tcw_pkg, tcw_ram, tcw_mod and tcw_walker.
`timescale 1ns / 1ps

// Usage
//  Commands enter on the s_* stream (operation in s_tuser, the rest in s_tdata); every
//  command returns exactly one beat on the m_* stream with the cell read (zero unless
//  read_cell) and the cursor after the command. The user must set the screen size
//  through the APB port (columns at 0x0, rows at 0x4) while no command is in flight;
//  the block does not enforce this. One command at a time; from accept to result load:
//   - put_char, move_to, read_cell: a reduction pass on the cursor, then on the target
//     for move_to and read_cell, and a store read for read_cell; a value in range
//     is reduced at once, one out of range bit-serially in the remainder units.
//   - clear, and a put_char that scrolls: add a sweep of columns*rows cells, one store
//     access per cell through the single write port of the screen RAM.
//  A new command is taken in the cycle after the previous result is loaded.
//  After reset the store is filled with spaces on attribute 0x0F, one cell per cycle,
//  with s_tready low until the fill is done.
//  When the receiver stalls, the result waits in the output register and the next
//  command is still accepted; it completes once the output register is free.

module text_console_writer_core #(
	parameter int MAX_COLUMNS = 80,
	parameter int MAX_ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // char_code[7:0], attribute[15:8], column[23:16], row[31:24]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // cell_char[7:0], cell_attribute[15:8],
	                              // cursor_column[22:16], cursor_row[27:23], zero above
);

	localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int COL_W = tcw_pkg::COL_W;
	localparam int ROW_W = tcw_pkg::ROW_W;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_INIT_WAIT,
		ST_IDLE,
		ST_CUR_WAIT,
		ST_IN_WAIT,
		ST_READ,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [COL_W-1:0] columns_q;
	logic [ROW_W-1:0] rows_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [7:0]       attr_q;
	logic [1:0]       op_q;
	logic [7:0]       ch_q;
	logic [7:0]       in_attr_q;
	logic [7:0]       in_col_q;
	logic [7:0]       in_row_q;
	logic [7:0]       res_char_q;
	logic [7:0]       res_attr_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic [7:0]       out_attr_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic [COL_W-1:0] nc;
	logic [ROW_W-1:0] nr;
	logic             cfg_wr;
	logic             s_accept;

	// remainder units
	logic             mod_start;
	logic [7:0]       mc_dvd;
	logic [7:0]       mr_dvd;
	logic             mc_busy;
	logic             mr_busy;
	logic [6:0]       mc_rem;
	logic [6:0]       mr_rem;
	logic             mods_idle;

	// store access
	logic [11:0]      cell_lin;
	logic [AW-1:0]    cell_addr;
	logic [11:0]      area;
	logic [CNT_W-1:0] total_cnt;
	logic [CNT_W-1:0] moved_cnt;
	logic             core_we;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	// walker
	logic               walk_start;
	tcw_pkg::walk_cmd_t walk_cmd;
	logic [CNT_W-1:0]   walk_total;
	logic               walk_busy;
	logic               w_we;
	logic [AW-1:0]      w_waddr;
	logic [tcw_pkg::CELL_W-1:0] w_wdata;
	logic [AW-1:0]      w_raddr;

	// put_char decode
	logic             is_nl;
	logic             is_cr;
	logic             printable;
	logic [7:0]       col_inc;
	logic [5:0]       row_inc;
	logic             wrap;
	logic             go_next;
	logic             last_row;
	logic             do_scroll;
	logic [COL_W-1:0] put_col;
	logic [ROW_W-1:0] put_row;

	// ---------------------------------------------------------------- config

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= tcw_pkg::COLUMNS_RESET;
			rows_q    <= tcw_pkg::ROWS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				tcw_pkg::REG_COLUMNS: columns_q <= pwdata[COL_W-1:0];
				tcw_pkg::REG_ROWS:    rows_q    <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tcw_pkg::REG_COLUMNS: prdata = {{(32-COL_W){1'b0}}, columns_q};
			tcw_pkg::REG_ROWS:    prdata = {{(32-ROW_W){1'b0}}, rows_q};
			default:              prdata = '0;
		endcase
	end

	// Size in use: zero acts as one, anything past the store acts as its maximum
	always_comb begin
		priority if (columns_q == '0) begin
			nc = COL_W'(1);
		end else if (int'(columns_q) > MAX_COLUMNS) begin
			nc = COL_W'(MAX_COLUMNS);
		end else begin
			nc = columns_q;
		end
		priority if (rows_q == '0) begin
			nr = ROW_W'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			nr = ROW_W'(MAX_ROWS);
		end else begin
			nr = rows_q;
		end
	end

	// ---------------------------------------------------------------- modulo

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign mods_idle = !mc_busy && !mr_busy;

	// First pass reduces the stored cursor, second pass (move_to and read_cell only) the command's target
	assign mod_start = s_accept ||
		((state_q == ST_CUR_WAIT) && mods_idle &&
		 ((op_q == tcw_pkg::OP_MOVE_TO) || (op_q == tcw_pkg::OP_READ_CELL)));
	assign mc_dvd = (state_q == ST_IDLE) ? {1'b0, cur_col_q} : in_col_q;
	assign mr_dvd = (state_q == ST_IDLE) ? {3'b000, cur_row_q} : in_row_q;

	tcw_mod u_mod_col (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mc_dvd),
		.divisor   (nc),
		.busy      (mc_busy),
		.remainder (mc_rem)
	);

	tcw_mod u_mod_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mr_dvd),
		.divisor   ({2'b00, nr}),
		.busy      (mr_busy),
		.remainder (mr_rem)
	);

	// ---------------------------------------------------------------- store

	assign cell_lin  = 12'(mr_rem[ROW_W-1:0]) * 12'(nc) + 12'(mc_rem);
	assign cell_addr = AW'(cell_lin);
	assign area      = 12'(nr) * 12'(nc);
	assign total_cnt = CNT_W'(area);
	assign moved_cnt = total_cnt - CNT_W'(nc);

	assign is_nl     = (ch_q == tcw_pkg::CHAR_NEWLINE);
	assign is_cr     = (ch_q == tcw_pkg::CHAR_RETURN);
	assign printable = !is_nl && !is_cr;
	assign col_inc   = {1'b0, mc_rem} + 8'd1;
	assign row_inc   = {1'b0, mr_rem[ROW_W-1:0]} + 6'd1;
	assign wrap      = printable && (col_inc >= {1'b0, nc});
	assign go_next   = is_nl || wrap;
	assign last_row  = row_inc >= {1'b0, nr};
	assign do_scroll = go_next && last_row;

	always_comb begin
		if (go_next) begin
			put_col = '0;
			put_row = last_row ? nr - ROW_W'(1) : row_inc[ROW_W-1:0];
		end else begin
			put_col = printable ? col_inc[COL_W-1:0] : mc_rem;
			put_row = mr_rem[ROW_W-1:0];
		end
	end

	assign core_we = (state_q == ST_CUR_WAIT) && mods_idle &&
		(op_q == tcw_pkg::OP_PUT_CHAR) && printable;

	assign walk_start = (state_q == ST_INIT) ||
		((state_q == ST_CUR_WAIT) && mods_idle &&
		 ((op_q == tcw_pkg::OP_CLEAR) || ((op_q == tcw_pkg::OP_PUT_CHAR) && do_scroll)));

	always_comb begin
		walk_cmd.scroll = (state_q == ST_CUR_WAIT) && (op_q == tcw_pkg::OP_PUT_CHAR);
		if (state_q == ST_INIT) begin
			walk_cmd.fill = {tcw_pkg::ATTR_DEFAULT, tcw_pkg::CHAR_SPACE};
			walk_total    = CNT_W'(CELLS);
		end else begin
			walk_cmd.fill = {in_attr_q, tcw_pkg::CHAR_SPACE};
			walk_total    = total_cnt;
		end
	end

	tcw_walker #(
		.CELLS (CELLS)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (walk_start),
		.cmd    (walk_cmd),
		.total  (walk_total),
		.moved  (moved_cnt),
		.nc     (nc),
		.busy   (walk_busy),
		.we     (w_we),
		.waddr  (w_waddr),
		.wdata  (w_wdata),
		.raddr  (w_raddr),
		.rdata  (ram_rdata)
	);

	assign ram_we    = walk_busy ? w_we : core_we;
	assign ram_waddr = walk_busy ? w_waddr : cell_addr;
	assign ram_wdata = walk_busy ? w_wdata : {attr_q, ch_q};
	assign ram_raddr = walk_busy ? w_raddr : cell_addr;

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- control

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			attr_q      <= tcw_pkg::ATTR_DEFAULT;
			op_q        <= tcw_pkg::OP_PUT_CHAR;
			ch_q        <= '0;
			in_attr_q   <= '0;
			in_col_q    <= '0;
			in_row_q    <= '0;
			res_char_q  <= '0;
			res_attr_q  <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_attr_q  <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					state_q <= ST_INIT_WAIT;
				end
				ST_INIT_WAIT: begin
					if (!walk_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						op_q      <= s_tuser;
						ch_q      <= s_tdata[7:0];
						in_attr_q <= s_tdata[15:8];
						in_col_q  <= s_tdata[23:16];
						in_row_q  <= s_tdata[31:24];
						state_q   <= ST_CUR_WAIT;
					end
				end
				ST_CUR_WAIT: begin
					if (mods_idle) begin
						res_char_q <= '0;
						res_attr_q <= '0;
						unique case (op_q)
							tcw_pkg::OP_PUT_CHAR: begin
								cur_col_q <= put_col;
								cur_row_q <= put_row;
								state_q   <= do_scroll ? ST_WALK : ST_DONE;
							end
							tcw_pkg::OP_CLEAR: begin
								attr_q    <= in_attr_q;
								cur_col_q <= '0;
								cur_row_q <= '0;
								state_q   <= ST_WALK;
							end
							default: begin
								// hold the reduced cursor, then reduce the target
								cur_col_q <= mc_rem;
								cur_row_q <= mr_rem[ROW_W-1:0];
								state_q   <= ST_IN_WAIT;
							end
						endcase
					end
				end
				ST_IN_WAIT: begin
					if (mods_idle) begin
						if (op_q == tcw_pkg::OP_MOVE_TO) begin
							cur_col_q <= mc_rem;
							cur_row_q <= mr_rem[ROW_W-1:0];
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					res_char_q <= ram_rdata[7:0];
					res_attr_q <= ram_rdata[15:8];
					state_q    <= ST_DONE;
				end
				ST_WALK: begin
					if (!walk_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// load the result beat once the output register is free
					if (!out_valid_q || m_tready) begin
						out_char_q  <= res_char_q;
						out_attr_q  <= res_attr_q;
						out_col_q   <= cur_col_q;
						out_row_q   <= cur_row_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_row_q, out_col_q, out_attr_q, out_char_q};

endmodule

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [WIDTH-1:0]        wdata,
	input  logic [AW-1:0]           raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tcw_mod.sv =====
// Iterative remainder unit: 8-bit dividend modulo a 7-bit nonzero divisor.
// One bit per cycle, restoring; a dividend already below the divisor finishes at once.
`timescale 1ns / 1ps

module tcw_mod (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dividend,
	input  logic [6:0] divisor,
	output logic       busy,
	output logic [6:0] remainder
);

	logic       busy_q;
	logic [2:0] step_q;
	logic [6:0] rem_q;
	logic [7:0] dvd_q;
	logic [6:0] dvs_q;
	logic [7:0] shifted;
	logic       take;

	assign shifted = {rem_q, dvd_q[7]};
	assign take    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= 7'd1;
		end else if (start) begin
			dvs_q <= divisor;
			if (dividend < {1'b0, divisor}) begin
				rem_q  <= dividend[6:0];
				busy_q <= 1'b0;
			end else begin
				rem_q  <= '0;
				dvd_q  <= dividend;
				step_q <= 3'd7;
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			rem_q  <= take ? 7'(shifted - {1'b0, dvs_q}) : shifted[6:0];
			dvd_q  <= {dvd_q[6:0], 1'b0};
			step_q <= step_q - 3'd1;
			if (step_q == 3'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/tcw_walker.sv =====
// Cell walker: sweeps the screen store one cell per cycle to fill it or scroll it.
// Depends on tcw_pkg; drives the store's ports while busy.
`timescale 1ns / 1ps

module tcw_walker #(
	parameter int CELLS  = 2000,
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1,
	localparam int CNT_W = $clog2(CELLS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  tcw_pkg::walk_cmd_t        cmd,
	input  logic [CNT_W-1:0]          total,
	input  logic [CNT_W-1:0]          moved,
	input  logic [tcw_pkg::COL_W-1:0] nc,
	output logic                      busy,
	output logic                      we,
	output logic [AW-1:0]             waddr,
	output logic [tcw_pkg::CELL_W-1:0] wdata,
	output logic [AW-1:0]             raddr,
	input  logic [tcw_pkg::CELL_W-1:0] rdata
);

	logic                       run_q;
	logic                       scroll_q;
	logic [tcw_pkg::CELL_W-1:0] fill_q;
	logic [CNT_W-1:0]           k_q;
	logic [CNT_W-1:0]           total_q;
	logic [CNT_W-1:0]           moved_q;
	logic [CNT_W-1:0]           nc_q;
	logic                       wr_s1;
	logic                       blank_s1;
	logic [AW-1:0]              wa_s1;
	logic [CNT_W-1:0]           src;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			wr_s1    <= 1'b0;
			scroll_q <= 1'b0;
			fill_q   <= '0;
			k_q      <= '0;
			total_q  <= '0;
			moved_q  <= '0;
			nc_q     <= '0;
			blank_s1 <= 1'b0;
			wa_s1    <= '0;
		end else begin
			wr_s1    <= run_q;
			wa_s1    <= k_q[AW-1:0];
			blank_s1 <= k_q >= moved_q;
			if (start) begin
				run_q    <= 1'b1;
				k_q      <= '0;
				scroll_q <= cmd.scroll;
				fill_q   <= cmd.fill;
				total_q  <= total;
				moved_q  <= moved;
				nc_q     <= CNT_W'(nc);
			end else if (run_q) begin
				k_q <= k_q + CNT_W'(1);
				if (k_q == total_q - CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Upper rows copy from one row below; the bottom row reads itself to keep its attributes
	assign src   = (scroll_q && (k_q < moved_q)) ? k_q + nc_q : k_q;
	assign raddr = src[AW-1:0];

	assign busy  = run_q || wr_s1;
	assign we    = wr_s1;
	assign waddr = wa_s1;

	always_comb begin
		if (!scroll_q) begin
			wdata = fill_q;
		end else if (blank_s1) begin
			wdata = {rdata[15:8], tcw_pkg::CHAR_SPACE};
		end else begin
			wdata = rdata;
		end
	end

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checks for the text console writer, attached to the top level by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module tcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// The store clearing pass keeps commands out right after reset
	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !s_tready)
		else $error("command accepted during the reset clearing pass");

	// One command at a time: an accepted beat drops ready
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second command taken while one is in flight");

	// A new result is loaded as its command retires, so the input side reopens
	a_result_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result appeared while a command is still in flight");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result beat changed or vanished");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/tb.sv =====
// Testbench for text_console_writer_core: command beats against a screen predictor,
// with APB size changes between phases and random stalls on both streams.
// Depends on tcw_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
	import tcw_pkg::*;

	localparam int MAX_COLUMNS = 80;
	localparam int MAX_ROWS    = 25;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 20000;
	localparam int ITEM_BUDGET = 1700;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [7:0] attr;
		logic [7:0] col;
		logic [7:0] row;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       ch;
		logic [7:0]       attr;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} report_t;

	typedef struct packed {
		logic    typed;
		cmd_t    cmd;
		report_t want;
	} dir_row_t;

	// Opening run at the reset size of 80x25; rows with typed = 1 carry their own result
	localparam dir_row_t DIRECTED_RUN [0:23] = '{
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0, CHAR_SPACE, ATTR_DEFAULT, 7'd0, 5'd0},
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd255, 8'd255, CHAR_SPACE, ATTR_DEFAULT, 7'd0, 5'd0},
		{1'b1, OP_PUT_CHAR, 8'h41, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 7'd1, 5'd0},
		{1'b1, OP_PUT_CHAR, CHAR_RETURN, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 7'd1, 5'd0},
		{1'b1, OP_PUT_CHAR, CHAR_NEWLINE, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 7'd0, 5'd1},
		{1'b1, OP_PUT_CHAR, 8'h00, 8'hFF, 8'd255, 8'd255, 8'h00, 8'h00, 7'd1, 5'd1},
		{1'b1, OP_PUT_CHAR, 8'hFF, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 7'd2, 5'd1},
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd1, 8'h00, ATTR_DEFAULT, 7'd2, 5'd1},
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0, 8'h41, ATTR_DEFAULT, 7'd2, 5'd1},
		{1'b1, OP_MOVE_TO, 8'h00, 8'h00, 8'd255, 8'd255, 8'h00, 8'h00, 7'd15, 5'd5},
		{1'b1, OP_MOVE_TO, 8'h00, 8'h00, 8'd79, 8'd24, 8'h00, 8'h00, 7'd79, 5'd24},
		{1'b1, OP_PUT_CHAR, 8'h7E, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 7'd0, 5'd24},
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd79, 8'd23, 8'h7E, ATTR_DEFAULT, 7'd0, 5'd24},
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0, 8'h00, ATTR_DEFAULT, 7'd0, 5'd24},
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd79, 8'd24, CHAR_SPACE, ATTR_DEFAULT, 7'd0, 5'd24},
		{1'b1, OP_CLEAR, 8'hFF, 8'h00, 8'd255, 8'd255, 8'h00, 8'h00, 7'd0, 5'd0},
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd5, 8'd5, CHAR_SPACE, 8'h00, 7'd0, 5'd0},
		{1'b1, OP_CLEAR, 8'h00, 8'hFF, 8'd0, 8'd0, 8'h00, 8'h00, 7'd0, 5'd0},
		{1'b1, OP_PUT_CHAR, 8'h55, 8'hAA, 8'd255, 8'd255, 8'h00, 8'h00, 7'd1, 5'd0},
		{1'b1, OP_MOVE_TO, 8'h00, 8'h00, 8'd0, 8'd24, 8'h00, 8'h00, 7'd0, 5'd24},
		{1'b1, OP_PUT_CHAR, CHAR_NEWLINE, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 7'd0, 5'd24},
		{1'b1, OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd23, CHAR_SPACE, 8'hFF, 7'd0, 5'd24},
		{1'b0, OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 7'd0, 5'd0},
		{1'b1, OP_MOVE_TO, 8'h00, 8'h00, 8'd79, 8'd24, 8'h00, 8'h00, 7'd79, 5'd24}
	};

	// Sizes right after the opening run: stale cursor, zero, oversize, single row/column
	localparam int EDGE_COLS [0:6] = '{7, 0, 127, 1, 80, 1, 80};
	localparam int EDGE_ROWS [0:6] = '{3, 0, 31, 1, 1, 25, 25};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [31:0] m_tdata;

	// Screen mirror
	logic [15:0]      screen [0:MAX_COLUMNS*MAX_ROWS-1];
	int unsigned      cur_col, cur_row;
	logic [7:0]       cur_attr;
	logic [COL_W-1:0] reg_cols;
	logic [ROW_W-1:0] reg_rows;

	report_t reports_due [$];
	int      errors, items_sent, reports_seen, reg_writes, phases, stuck;
	bit      burst, hold_long;
	int      fast_left;

	always #5 clk = ~clk;

	text_console_writer_core #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	function automatic int unsigned in_use(int unsigned value, int unsigned limit);
		if (value == 0) return 1;
		return (value > limit) ? limit : value;
	endfunction

	function automatic void line_feed(int unsigned nc, int unsigned nr);
		int unsigned i;
		if (cur_row + 1 >= nr) begin
			for (i = 0; i < (nr - 1) * nc; i++)
				screen[i] = screen[i + nc];
			// bottom row: blank the characters, keep the attributes
			for (i = 0; i < nc; i++)
				screen[(nr - 1) * nc + i][7:0] = CHAR_SPACE;
			cur_row = nr - 1;
		end else begin
			cur_row++;
		end
		cur_col = 0;
	endfunction

	function automatic report_t console_apply(cmd_t c);
		int unsigned nc, nr, k;
		report_t r;
		nc = in_use(32'(reg_cols), MAX_COLUMNS);
		nr = in_use(32'(reg_rows), MAX_ROWS);
		r = '0;
		cur_col = cur_col % nc;
		cur_row = cur_row % nr;
		case (c.op)
			OP_PUT_CHAR: begin
				if (c.ch == CHAR_NEWLINE) begin
					line_feed(nc, nr);
				end else if (c.ch != CHAR_RETURN) begin
					screen[cur_row * nc + cur_col] = {cur_attr, c.ch};
					cur_col++;
					if (cur_col >= nc) line_feed(nc, nr);
				end
			end
			OP_CLEAR: begin
				cur_attr = c.attr;
				cur_col = 0;
				cur_row = 0;
				for (k = 0; k < nc * nr; k++)
					screen[k] = {c.attr, CHAR_SPACE};
			end
			OP_MOVE_TO: begin
				cur_col = c.col % nc;
				cur_row = c.row % nr;
			end
			default: begin
				k = (c.row % nr) * nc + (c.col % nc);
				r.ch = screen[k][7:0];
				r.attr = screen[k][15:8];
			end
		endcase
		r.col = cur_col[COL_W-1:0];
		r.row = cur_row[ROW_W-1:0];
		return r;
	endfunction

	function automatic cmd_t random_cmd(int unsigned nc, int unsigned nr);
		cmd_t c;
		int unsigned pick, clear_w;
		clear_w = (nc * nr > 400) ? 1 : 6;
		c.ch = 8'($urandom_range(0, 255));
		c.attr = 8'($urandom_range(0, 255));
		c.col = 8'($urandom_range(0, 1) ? $urandom_range(0, nc - 1) : $urandom_range(0, 255));
		c.row = 8'($urandom_range(0, 1) ? $urandom_range(0, nr - 1) : $urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < clear_w) begin
			c.op = OP_CLEAR;
		end else if (pick < 60) begin
			c.op = OP_PUT_CHAR;
			pick = $urandom_range(0, 19);
			if (pick < 2) c.ch = CHAR_NEWLINE;
			else if (pick == 2) c.ch = CHAR_RETURN;
		end else if (pick < 75) begin
			c.op = OP_MOVE_TO;
		end else begin
			c.op = OP_READ_CELL;
		end
		return c;
	endfunction

	task automatic apb_write(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_COLUMNS) reg_cols = value[COL_W-1:0];
		else reg_rows = value[ROW_W-1:0];
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic send_cmd(input cmd_t c, input logic typed, input report_t want);
		int gap;
		report_t r;
		gap = (burst || fast_left > 0) ? 0 : $urandom_range(0, 9);
		if (fast_left > 0) fast_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {c.row, c.col, c.attr, c.ch};
		s_tuser <= c.op;
		do @(posedge clk); while (!s_tready);
		r = console_apply(c);
		reports_due.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic drain_reports();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int cols, input int rows, input int count);
		int unsigned nc, nr;
		int n, hold_at, pause_at;
		// random upper bits: only the low bits of each register count
		apb_write(REG_COLUMNS, ($urandom() & ~32'h7F) | (cols & 32'h7F));
		apb_write(REG_ROWS, ($urandom() & ~32'h1F) | (rows & 32'h1F));
		nc = in_use(32'(reg_cols), MAX_COLUMNS);
		nr = in_use(32'(reg_rows), MAX_ROWS);
		burst = ($urandom_range(0, 3) == 0);
		hold_at = $urandom_range(0, count - 1);
		pause_at = $urandom_range(0, count - 1);
		for (n = 0; n < count; n++) begin
			if (n == hold_at) begin
				hold_long = 1'b1;
				fast_left = 12;
			end
			if (n == pause_at) drain_reports();
			send_cmd(random_cmd(nc, nr), 1'b0, '0);
		end
		drain_reports();
		burst = 1'b0;
		phases++;
	endtask

	task automatic check_report(input logic [31:0] d);
		report_t e;
		reports_seen++;
		if (reports_due.size() == 0) begin
			$error("result beat %h with no command outstanding", d);
			errors++;
			return;
		end
		e = reports_due.pop_front();
		if (d[7:0] !== e.ch) begin
			$error("cell_char: expected %0h, got %0h", e.ch, d[7:0]);
			errors++;
		end
		if (d[15:8] !== e.attr) begin
			$error("cell_attribute: expected %0h, got %0h", e.attr, d[15:8]);
			errors++;
		end
		if (d[22:16] !== e.col) begin
			$error("cursor_column: expected %0d, got %0d", e.col, d[22:16]);
			errors++;
		end
		if (d[27:23] !== e.row) begin
			$error("cursor_row: expected %0d, got %0d", e.row, d[27:23]);
			errors++;
		end
		if (d[31:28] !== 4'd0) begin
			$error("tdata padding: expected 0, got %0h", d[31:28]);
			errors++;
		end
	endtask

	// Result side: random stall per beat, one long hold-off on request
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_long) begin
				stall = HOLD_CYCLES;
				hold_long = 1'b0;
			end else begin
				stall = burst ? 0 : $urandom_range(0, 9);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_report(m_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck <= 0;
		else stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int i, cols, rows;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_PUT_CHAR;
		errors = 0;
		for (i = 0; i < MAX_COLUMNS * MAX_ROWS; i++)
			screen[i] = {ATTR_DEFAULT, CHAR_SPACE};
		cur_col = 0;
		cur_row = 0;
		cur_attr = ATTR_DEFAULT;
		reg_cols = COLUMNS_RESET;
		reg_rows = ROWS_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(DIRECTED_RUN); i++)
			send_cmd(DIRECTED_RUN[i].cmd, DIRECTED_RUN[i].typed, DIRECTED_RUN[i].want);
		drain_reports();

		for (i = 0; i < $size(EDGE_COLS); i++)
			run_phase(EDGE_COLS[i], EDGE_ROWS[i], 40);

		// mostly small screens keep scrolls and clears cheap; a few span the whole range
		while (items_sent < ITEM_BUDGET) begin
			if ($urandom_range(0, 4) == 0) begin
				cols = $urandom_range(0, 127);
				rows = $urandom_range(0, 31);
			end else begin
				cols = $urandom_range(1, 16);
				rows = $urandom_range(1, 8);
			end
			run_phase(cols, rows, $urandom_range(80, 140));
		end

		drain_reports();
		repeat (40) @(posedge clk);
		if (reports_due.size() != 0) begin
			$error("%0d results never arrived", reports_due.size());
			errors++;
		end
		$display("Sent %0d commands over %0d screen sizes with %0d register writes;",
			items_sent, phases, reg_writes);
		$display("checked %0d result beats, %0d mismatches.", reports_seen, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
